/* src/bfpa_pkg.sv */
// Shared types and constants of the bitmap first-fit page allocator.
// Holds request and response item structs, status, kind and register codes.
// Used by every module in src.
package bfpa_pkg;

	localparam int POOL_PAGES_DEF = 256;
	localparam int PAGE_BYTES_DEF = 4096;

	localparam int ADDR_W        = 32;
	localparam int SIZE_W        = 32;
	localparam int STATUS_W      = 3;
	localparam int FREE_W        = 21;
	localparam int MAP_WORD_BITS = 32;
	localparam int WORD_BIT_W    = $clog2(MAP_WORD_BITS);

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	localparam logic REG_VIRT_BASE = 1'b0;
	localparam logic REG_PHYS_BASE = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_BAD_ADDR  = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_PAST_END  = 3'd4;

	typedef struct packed {
		logic              kind;
		logic [SIZE_W-1:0] size_bytes;
		logic [ADDR_W-1:0] release_addr;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   virt_addr;
		logic [ADDR_W-1:0]   phys_addr;
		logic [FREE_W-1:0]   free_bytes;
	} out_item_t;

endpackage

/* src/bfpa_map_mem.sv */
// Occupancy map memory: one 32-bit word of page-used bits per entry.
// One read and one write port, registered read; a word never written reads as zero.
// Depends on bfpa_pkg.
module bfpa_map_mem import bfpa_pkg::*; #(
	parameter int WORDS = 8,
	parameter int AW    = 3
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [AW-1:0]            rd_addr,
	output logic [MAP_WORD_BITS-1:0] rd_data,
	input  logic                     wr_en,
	input  logic [AW-1:0]            wr_addr,
	input  logic [MAP_WORD_BITS-1:0] wr_data
);

	logic [MAP_WORD_BITS-1:0] mem [WORDS];
	logic [WORDS-1:0]         vld_q;
	logic [MAP_WORD_BITS-1:0] rd_word_s1;
	logic                     rd_vld_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_word_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_s1 <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_s1 ? rd_word_s1 : '0;

endmodule

/* src/bfpa_run_find.sv */
// Free-run finder for one map word: extends the run carried in from lower words
// and reports the start page of the run of the needed length that ends lowest.
// Depends on bfpa_pkg.
module bfpa_run_find import bfpa_pkg::*; #(
	parameter int POOL_PAGES = POOL_PAGES_DEF,
	parameter int WORD_AW    = 3,
	parameter int RUN_W      = 15
) (
	input  logic [MAP_WORD_BITS-1:0]       word_used,
	input  logic [WORD_AW-1:0]             word_idx,
	input  logic [RUN_W-1:0]               carry_run,
	input  logic [RUN_W-1:0]               need,
	output logic                           found,
	output logic [WORD_AW+WORD_BIT_W-1:0]  start,
	output logic [RUN_W-1:0]               run_out
);

	localparam int PAGE_IDX_W = WORD_AW + WORD_BIT_W;
	localparam int SW         = RUN_W + PAGE_IDX_W;

	logic [MAP_WORD_BITS-1:0] busy;
	logic [MAP_WORD_BITS-1:0] hit;
	logic [WORD_BIT_W-1:0]    lb [MAP_WORD_BITS];
	logic [RUN_W-1:0]         run [MAP_WORD_BITS];
	logic [WORD_BIT_W-1:0]    fj;
	logic [SW-1:0]            start_wide;

	// pages past the pool end count as busy
	always_comb begin
		for (int j = 0; j < MAP_WORD_BITS; j++) begin
			busy[j] = word_used[j] |
				({1'b0, word_idx, WORD_BIT_W'(j)} >= (PAGE_IDX_W+1)'(POOL_PAGES));
		end
	end

	always_comb begin
		found = 1'b0;
		fj    = '0;
		for (int j = 0; j < MAP_WORD_BITS; j++) begin
			hit[j] = 1'b0;
			lb[j]  = '0;
			for (int k = 0; k <= j; k++) begin
				if (busy[k]) begin
					hit[j] = 1'b1;
					lb[j]  = WORD_BIT_W'(k);
				end
			end
			run[j] = hit[j] ? RUN_W'(WORD_BIT_W'(j) - lb[j]) : carry_run + RUN_W'(j + 1);
		end
		// lowest end position wins
		for (int j = MAP_WORD_BITS - 1; j >= 0; j--) begin
			if (run[j] >= need) begin
				found = 1'b1;
				fj    = WORD_BIT_W'(j);
			end
		end
	end

	assign start_wide = SW'({word_idx, fj}) + SW'(1) - SW'(need);
	assign start      = start_wide[PAGE_IDX_W-1:0];
	assign run_out    = run[MAP_WORD_BITS-1];

endmodule

/* src/bitmap_first_fit_page_allocator_unit.sv */
// Top level of the bitmap first-fit page allocator.
// Sequencer, request checks and map read-modify-write; uses bfpa_pkg,
// bfpa_map_mem and bfpa_run_find.
//
// channel  direction  handshake                 payload
// req      in         req_valid / req_stall     in_item_t  (kind, size, release address)
// rsp      out        rsp_valid / rsp_stall     out_item_t (status, addresses, free bytes)
// cfg      in         cfg_we                    cfg_index, cfg_wdata
//
// One item at a time. An empty request, an oversized allocate or a bad address is
// answered from the check state; a range past the pool end also passes the range state.
// An allocate scans the map one 32-page word per cycle, then rewrites the words of the
// run one per cycle and waits for the last write to drain. A free rewrites the words
// of its range the same way, without a scan. The result is in the output register when
// the block returns to idle and can accept the next item.
// Reset empties the map at once through per-word valid bits; no clearing pass.
// req_stall is high from acceptance until the result sits in the output register;
// a stalled rsp holds the block in its final state. PAGE_BYTES must be a power of two.
module bitmap_first_fit_page_allocator_unit import bfpa_pkg::*; #(
	parameter int POOL_PAGES = POOL_PAGES_DEF,
	parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  in_item_t          req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output out_item_t         rsp,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [ADDR_W-1:0] cfg_wdata
);

	localparam int MAP_WORDS  = (POOL_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int WORD_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int PAGE_IDX_W = WORD_AW + WORD_BIT_W;
	localparam int PIU_W      = $clog2(POOL_PAGES + 1);
	localparam int RUN_W      = PIU_W + WORD_BIT_W + 1;
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int NEED_W     = SIZE_W + 1 - PAGE_SHIFT;
	localparam logic [ADDR_W:0] POOL_SPAN = (ADDR_W+1)'(POOL_PAGES * PAGE_BYTES);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_RANGE = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_SPAN  = 3'd4;
	localparam logic [2:0] S_RMW   = 3'd5;
	localparam logic [2:0] S_UPD   = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0]              state_q;
	logic [ADDR_W-1:0]       virt_base_q;
	logic [ADDR_W-1:0]       phys_base_q;
	logic                    kind_q;
	logic                    size_zero_q;
	logic [ADDR_W-1:0]       addr_q;
	logic [NEED_W-1:0]       need_q;
	logic [STATUS_W-1:0]     status_q;
	logic [PAGE_IDX_W-1:0]   lo_q;
	logic [PAGE_IDX_W-1:0]   hi_q;
	logic [PAGE_IDX_W-1:0]   first_q;
	logic [WORD_AW:0]        rd_w_q;
	logic [WORD_AW-1:0]      data_w_s1;
	logic                    pend_s1;
	logic [RUN_W-1:0]        carry_q;
	logic [PIU_W-1:0]        piu_q;
	logic                    rsp_valid_q;
	out_item_t               rsp_q;

	logic                    req_acc;
	logic                    rsp_take;
	logic [SIZE_W:0]         size_round;
	logic [NEED_W-1:0]       need_next;
	logic [ADDR_W:0]         pool_end;
	logic                    addr_bad;
	logic [ADDR_W-1:0]       addr_off;
	logic [NEED_W:0]         range_end;
	logic                    rd_en;
	logic [WORD_AW-1:0]      rd_addr;
	logic                    rmw_rd;
	logic [MAP_WORD_BITS-1:0] rd_data;
	logic                    wr_en;
	logic [MAP_WORD_BITS-1:0] wr_data;
	logic [MAP_WORD_BITS-1:0] mask;
	logic [WORD_AW-1:0]      lo_w;
	logic [WORD_AW-1:0]      hi_w;
	logic [WORD_BIT_W-1:0]   lo_b;
	logic [WORD_BIT_W-1:0]   hi_b;
	logic                    rf_found;
	logic [PAGE_IDX_W-1:0]   rf_start;
	logic [RUN_W-1:0]        rf_run;
	logic [PIU_W-1:0]        need_pg;
	logic [PIU_W:0]          piu_sum;
	logic [PIU_W-1:0]        free_pages;
	logic [63:0]             free_wide;
	logic                    alloc_ok;

	assign req_stall = (state_q != S_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_take  = rsp_valid_q && !rsp_stall;

	assign size_round = (SIZE_W+1)'(req.size_bytes) + (SIZE_W+1)'(PAGE_BYTES - 1);
	assign need_next  = NEED_W'(size_round >> PAGE_SHIFT);

	assign pool_end  = (ADDR_W+1)'(virt_base_q) + POOL_SPAN;
	assign addr_bad  = (addr_q < virt_base_q) || ((ADDR_W+1)'(addr_q) >= pool_end) ||
		(addr_q[PAGE_SHIFT-1:0] != '0);
	assign addr_off  = addr_q - virt_base_q;
	assign range_end = (NEED_W+1)'(first_q) + (NEED_W+1)'(need_q);

	assign need_pg = PIU_W'(need_q);
	assign lo_w    = lo_q[PAGE_IDX_W-1:WORD_BIT_W];
	assign hi_w    = hi_q[PAGE_IDX_W-1:WORD_BIT_W];

	// map read port: word 0 in the check state, then the running word counter
	assign rmw_rd = (state_q == S_RMW) && (rd_w_q <= {1'b0, hi_w});
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = rd_w_q[WORD_AW-1:0];
		case (state_q)
			S_CHECK: begin
				rd_en   = 1'b1;
				rd_addr = '0;
			end
			S_SCAN: begin
				rd_en = (rd_w_q < (WORD_AW+1)'(MAP_WORDS));
			end
			S_RMW: begin
				rd_en = rmw_rd;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// bits of the current word that fall inside [lo, hi]
	always_comb begin
		lo_b = (data_w_s1 == lo_w) ? lo_q[WORD_BIT_W-1:0] : '0;
		hi_b = (data_w_s1 == hi_w) ? hi_q[WORD_BIT_W-1:0] : '1;
		for (int j = 0; j < MAP_WORD_BITS; j++) begin
			mask[j] = (WORD_BIT_W'(j) >= lo_b) && (WORD_BIT_W'(j) <= hi_b);
		end
	end

	assign wr_en   = (state_q == S_RMW) && pend_s1;
	assign wr_data = (kind_q == KIND_ALLOC) ? (rd_data | mask) : (rd_data & ~mask);

	bfpa_map_mem #(
		.WORDS (MAP_WORDS),
		.AW    (WORD_AW)
	) u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (data_w_s1),
		.wr_data (wr_data)
	);

	bfpa_run_find #(
		.POOL_PAGES (POOL_PAGES),
		.WORD_AW    (WORD_AW),
		.RUN_W      (RUN_W)
	) u_find (
		.word_used (rd_data),
		.word_idx  (data_w_s1),
		.carry_run (carry_q),
		.need      (RUN_W'(need_q)),
		.found     (rf_found),
		.start     (rf_start),
		.run_out   (rf_run)
	);

	assign piu_sum    = (PIU_W+1)'(piu_q) + (PIU_W+1)'(need_pg);
	assign free_pages = PIU_W'(POOL_PAGES) - piu_q;
	assign free_wide  = 64'(free_pages) << PAGE_SHIFT;
	assign alloc_ok   = (kind_q == KIND_ALLOC) && (status_q == STATUS_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			virt_base_q <= '0;
			phys_base_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_VIRT_BASE) begin
				virt_base_q <= cfg_wdata;
			end else begin
				phys_base_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			kind_q      <= req.kind;
			size_zero_q <= (req.size_bytes == '0);
			addr_q      <= req.release_addr;
			need_q      <= need_next;
		end
		if (rd_en) begin
			data_w_s1 <= rd_addr;
		end
		case (state_q)
			S_CHECK: begin
				first_q <= PAGE_IDX_W'(addr_off >> PAGE_SHIFT);
				carry_q <= '0;
			end
			S_RANGE: begin
				lo_q <= first_q;
			end
			S_SCAN: begin
				lo_q    <= rf_start;
				carry_q <= rf_run;
			end
			S_SPAN: begin
				hi_q <= lo_q + need_pg[PAGE_IDX_W-1:0] - PAGE_IDX_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			status_q    <= STATUS_OK;
			rd_w_q      <= '0;
			pend_s1     <= 1'b0;
			piu_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			pend_s1 <= rmw_rd;
			if (rd_en) begin
				rd_w_q <= rd_w_q + (WORD_AW+1)'(1);
			end
			if (rsp_take) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					status_q <= STATUS_OK;
					rd_w_q   <= (WORD_AW+1)'(1);
					if (size_zero_q || (kind_q == KIND_FREE && addr_q == '0)) begin
						status_q <= STATUS_EMPTY;
						state_q  <= S_DONE;
					end else if (kind_q == KIND_ALLOC) begin
						if (need_q > NEED_W'(POOL_PAGES)) begin
							status_q <= STATUS_EXHAUSTED;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end else if (addr_bad) begin
						status_q <= STATUS_BAD_ADDR;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_RANGE;
					end
				end
				S_RANGE: begin
					if (range_end > (NEED_W+1)'(POOL_PAGES)) begin
						status_q <= STATUS_PAST_END;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_SPAN;
					end
				end
				S_SCAN: begin
					if (rf_found) begin
						state_q <= S_SPAN;
					end else if (data_w_s1 == WORD_AW'(MAP_WORDS - 1)) begin
						status_q <= STATUS_EXHAUSTED;
						state_q  <= S_DONE;
					end
				end
				S_SPAN: begin
					rd_w_q  <= {1'b0, lo_w};
					state_q <= S_RMW;
				end
				S_RMW: begin
					if (!rmw_rd && !pend_s1) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (kind_q == KIND_ALLOC) begin
						piu_q <= (piu_sum > (PIU_W+1)'(POOL_PAGES)) ?
							PIU_W'(POOL_PAGES) : piu_sum[PIU_W-1:0];
					end else begin
						piu_q <= (piu_q > need_pg) ? (piu_q - need_pg) : '0;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (!rsp_valid_q || rsp_take) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!rsp_valid_q || rsp_take)) begin
			rsp_q.status     <= status_q;
			rsp_q.virt_addr  <= alloc_ok ?
				(virt_base_q + (ADDR_W'(lo_q) << PAGE_SHIFT)) : '0;
			rsp_q.phys_addr  <= alloc_ok ?
				(phys_base_q + (ADDR_W'(lo_q) << PAGE_SHIFT)) : '0;
			rsp_q.free_bytes <= free_wide[FREE_W-1:0];
		end
	end

`ifndef ASSERT_OFF
	a_piu_bound: assert property (@(posedge clk) disable iff (!arst_n)
		piu_q <= PIU_W'(POOL_PAGES))
		else $error("pages in use above pool size");

	a_fail_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != STATUS_OK |-> rsp.virt_addr == '0 && rsp.phys_addr == '0)
		else $error("failed request returned an address");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> req_stall)
		else $error("new item taken while one is in work");

	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RMW |-> lo_q <= hi_q)
		else $error("page span reversed during map update");
`endif

endmodule
